[rtl/iva_pkg.sv]
`default_nettype none

package iva_pkg;

  // Map geometry and the fixed vector layout.
  localparam int NUM_VECTORS       = 256;
  localparam int FIRST_FREE_VECTOR = 48;
  localparam int RESERVED_VECTOR   = 8'h80;
  localparam int VEC_W             = 8;
  localparam int WORD_W            = 32;
  localparam int BIT_W             = $clog2(WORD_W);
  localparam int NUM_WORDS         = (NUM_VECTORS + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W        = $clog2(NUM_WORDS);
  localparam int FIRST_WORD        = FIRST_FREE_VECTOR / WORD_W;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [VEC_W-1:0]      vec_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and restart the scan
    logic scan_step;  // examine one map word, claim its lowest free bit
    logic free_exec;  // clear the in-use bit of the captured vector
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;      // current map word holds an allocatable vector
    logic last_word;  // scan index sits on the last map word
    logic out_ready;  // output register can take a result this cycle
  } status_t;

  // Bits of a map word that an allocation may hand out.
  function automatic word_t avail_mask(input word_idx_t w);
    word_t m;
    int    v;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      v = int'(w) * WORD_W + b;
      m[b] = (v >= FIRST_FREE_VECTOR) && (v != RESERVED_VECTOR) && (v < NUM_VECTORS);
    end
    return m;
  endfunction

  // In-use pattern of a map word after reset.
  function automatic word_t map_reset_word(input word_idx_t w);
    word_t m;
    int    v;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      v = int'(w) * WORD_W + b;
      m[b] = (v < FIRST_FREE_VECTOR) || (v == RESERVED_VECTOR);
    end
    return m;
  endfunction

  // Bit position of a one-hot word.
  function automatic logic [BIT_W-1:0] onehot_index(input word_t oh);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (oh[b]) begin
        idx = idx | BIT_W'(b);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/iva_ctrl.sv]
`default_nettype none

module iva_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_op,
  output logic                in_stall,
  input  wire iva_pkg::status_t status,
  output iva_pkg::cmd_t       cmd
);

  iva_pkg::state_t state_r;
  iva_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iva_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == iva_pkg::OP_FREE) ? iva_pkg::ST_FREE : iva_pkg::ST_SCAN;
        end
      end
      iva_pkg::ST_SCAN: begin
        if (status.found || status.last_word) begin
          state_nxt = iva_pkg::ST_RESULT;
        end
      end
      iva_pkg::ST_FREE:   state_nxt = iva_pkg::ST_RESULT;
      iva_pkg::ST_RESULT: begin
        if (status.out_ready) begin
          state_nxt = iva_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      iva_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      iva_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      iva_pkg::ST_FREE:   cmd.free_exec = 1'b1;
      iva_pkg::ST_RESULT: cmd.out_load  = status.out_ready;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iva_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/iva_datapath.sv]
`default_nettype none

module iva_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_op,
  input  wire logic [iva_pkg::VEC_W-1:0] in_vector_in,
  output logic [iva_pkg::VEC_W-1:0]    out_vector_out,
  output logic                         out_granted,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire iva_pkg::cmd_t           cmd,
  output iva_pkg::status_t             status
);

  iva_pkg::word_t     map_r   [iva_pkg::NUM_WORDS];
  iva_pkg::word_t     map_nxt [iva_pkg::NUM_WORDS];
  iva_pkg::word_idx_t idx_r,   idx_nxt;
  iva_pkg::vec_t      vec_r,   vec_nxt;
  iva_pkg::vec_t      res_vec_r, res_vec_nxt;
  logic               res_grant_r, res_grant_nxt;
  iva_pkg::vec_t      out_vec_r, out_vec_nxt;
  logic               out_grant_r, out_grant_nxt;
  logic               out_valid_r, out_valid_nxt;

  iva_pkg::word_t     free_bits;
  iva_pkg::word_t     lowest;
  logic [iva_pkg::BIT_W-1:0] bit_pos;
  iva_pkg::word_idx_t free_word;
  logic               free_ok;

  // Lowest free, allocatable bit of the word under the scan index.
  assign free_bits = ~map_r[idx_r] & iva_pkg::avail_mask(idx_r);
  assign lowest    = free_bits & (~free_bits + iva_pkg::WORD_W'(1));
  assign bit_pos   = iva_pkg::onehot_index(lowest);

  assign free_word = iva_pkg::WORD_IDX_W'(vec_r >> iva_pkg::BIT_W);
  assign free_ok   = (int'(vec_r) >= iva_pkg::FIRST_FREE_VECTOR) &&
                     (int'(vec_r) != iva_pkg::RESERVED_VECTOR) &&
                     (int'(vec_r) <  iva_pkg::NUM_VECTORS);

  assign status.found     = |free_bits;
  assign status.last_word = (int'(idx_r) == iva_pkg::NUM_WORDS - 1);
  assign status.out_ready = !out_valid_r || !out_stall;

  always_comb begin
    map_nxt       = map_r;
    idx_nxt       = idx_r;
    vec_nxt       = vec_r;
    res_vec_nxt   = res_vec_r;
    res_grant_nxt = res_grant_r;
    out_vec_nxt   = out_vec_r;
    out_grant_nxt = out_grant_r;
    out_valid_nxt = out_valid_r;

    if (cmd.load) begin
      idx_nxt       = iva_pkg::WORD_IDX_W'(iva_pkg::FIRST_WORD);
      vec_nxt       = (in_op == iva_pkg::OP_FREE) ? in_vector_in : '0;
      res_vec_nxt   = '0;
      res_grant_nxt = 1'b0;
    end

    if (cmd.scan_step) begin
      if (status.found) begin
        map_nxt[idx_r] = map_r[idx_r] | lowest;
        res_vec_nxt    = iva_pkg::VEC_W'({idx_r, bit_pos});
        res_grant_nxt  = 1'b1;
      end else if (!status.last_word) begin
        idx_nxt = idx_r + iva_pkg::WORD_IDX_W'(1);
      end
    end

    if (cmd.free_exec && free_ok) begin
      map_nxt[free_word] = map_r[free_word] &
                           ~(iva_pkg::WORD_W'(1) << vec_r[iva_pkg::BIT_W-1:0]);
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_vec_nxt   = res_vec_r;
      out_grant_nxt = res_grant_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < iva_pkg::NUM_WORDS; w++) begin
        map_r[w] <= iva_pkg::map_reset_word(iva_pkg::WORD_IDX_W'(w));
      end
      out_valid_r <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    vec_r       <= vec_nxt;
    res_vec_r   <= res_vec_nxt;
    res_grant_r <= res_grant_nxt;
    out_vec_r   <= out_vec_nxt;
    out_grant_r <= out_grant_nxt;
  end

  assign out_vector_out = out_vec_r;
  assign out_granted    = out_grant_r;
  assign out_valid      = out_valid_r;

endmodule

`default_nettype wire

[rtl/interrupt_vector_allocator_top.sv]
// Channel  | Ports                                  | Direction | Beat carries
// ---------+----------------------------------------+-----------+--------------------------
// request  | in_valid, in_stall, in_op, in_vector_in | in        | allocate, or free a vector
// result   | out_valid, out_stall, out_vector_out,   | out       | granted vector and flag
//          | out_granted                            |           |
//
// An allocate beat scans the in-use map from word FIRST_WORD up to the last word:
// the scan examines one 32-bit map word per cycle and stops at the first word
// with a free vector. A free beat clears the in-use bit of its vector. Reset is
// synchronous and active low; it loads the in-use map with the reserved pattern.
// A result beat waits in the output register while out_stall is high; the next
// request is taken as soon as the finished result has moved into that register.
`default_nettype none

module interrupt_vector_allocator_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_op,
  input  wire logic [iva_pkg::VEC_W-1:0] in_vector_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [iva_pkg::VEC_W-1:0]      out_vector_out,
  output logic                           out_granted
);

  // The controller sequences each request: capture, then either a word-by-word
  // scan of the in-use map or a single clear, then a hand-off to the output.
  iva_pkg::cmd_t    cmd;
  iva_pkg::status_t status;

  iva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the in-use map as 32-bit words, the scan index, the
  // pending result and the output register.
  iva_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_vector_in   (in_vector_in),
    .out_vector_out (out_vector_out),
    .out_granted    (out_granted),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

`default_nettype wire

[rtl/iva_checker.sv]
`default_nettype none

module iva_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [iva_pkg::VEC_W-1:0] out_vector_out,
  input wire logic                      out_granted
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vector_out) && $stable(out_granted))
    else $error("result beat changed while stalled");

  // A refused or free result carries vector zero.
  a_zero_on_deny: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_vector_out == '0)
    else $error("ungranted result with nonzero vector");

  // A granted vector is never a protected one.
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |->
      (int'(out_vector_out) >= iva_pkg::FIRST_FREE_VECTOR) &&
      (int'(out_vector_out) != iva_pkg::RESERVED_VECTOR) &&
      (int'(out_vector_out) <  iva_pkg::NUM_VECTORS))
    else $error("granted a protected vector");

  // The block is busy right after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in progress");

endmodule

bind interrupt_vector_allocator_top iva_checker u_iva_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_vector_out (out_vector_out),
  .out_granted    (out_granted)
);

`default_nettype wire
